// ===== sv/wsc_pkg.sv =====
// Shared types and constants for the WSClock page replacement block.
`timescale 1ns / 1ps

package wsc_pkg;

   // Frame table depth and derived widths
   localparam int FRAMES    = 64;
   localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int NW        = $clog2(FRAMES + 1);
   localparam int CNT_W     = NW + 1;

   // Field widths fixed by the interface
   localparam int SLOT_W    = 10;
   localparam int PAGE_W    = 32;
   localparam int ADDR_W    = 32;
   localparam int TIME_W    = 31;
   localparam int FIU_W     = 11;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 31;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_LOAD_DONE = 2'd0,
      STATUS_REPLACED  = 2'd1,
      STATUS_NO_VICTIM = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AGE_THRESHOLD = 1'b0,
      CSR_FRAMES_IN_USE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic do_load;
      logic setup;
      logic sweep;
      logic publish;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic replace;
      logic victim;
      logic exhausted;
   } dp_status_type;

endpackage

// ===== sv/wsc_ctrl.sv =====
// Controller state machine sequencing loads, sweeps and result hand-off.
`timescale 1ns / 1ps

module wsc_ctrl
   import wsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type stat
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // State and output-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (stat.replace) begin
               cmd.setup = 1'b1;
               state_in  = ST_SWEEP;
            end else begin
               cmd.do_load = 1'b1;
               state_in    = ST_FINISH;
            end
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (stat.victim || stat.exhausted) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result beat until taken
   always_comb begin
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result published over a waiting beat");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish state");

   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && (stat.victim || stat.exhausted)) |=> state_ff == ST_FINISH)
      else $error("sweep did not end on victim or exhaustion");
`endif

endmodule

// ===== sv/wsc_datapath.sv =====
// Frame table, clock hand, sweep pointers and result registers.
`timescale 1ns / 1ps

module wsc_datapath
   import wsc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_status_type        stat,
   // input beat
   input  logic                 req_kind,
   input  logic [SLOT_W-1:0]    req_slot,
   input  logic [PAGE_W-1:0]    req_page_number,
   input  logic [ADDR_W-1:0]    req_virt_address,
   input  logic [TIME_W-1:0]    req_now_time,
   input  logic                 req_write_flag,
   // configuration
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   // result beat
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [PAGE_W-1:0]    rsp_evicted_page,
   output logic [ADDR_W-1:0]    rsp_evicted_address,
   output logic [SLOT_W-1:0]    rsp_frame_used,
   output logic [SLOT_W-1:0]    rsp_next_hand
);

   // Frame table memories
   logic [PAGE_W-1:0] page_mem [FRAMES];
   logic [ADDR_W-1:0] addr_mem [FRAMES];
   logic [TIME_W-1:0] last_mem [FRAMES];
   logic [FRAMES-1:0] dirty_ff, occupied_ff;

   logic [PAGE_W-1:0] rd_page_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic [TIME_W-1:0] rd_last_ff;

   // Configuration registers
   logic [TIME_W-1:0] age_threshold_ff;
   logic [FIU_W-1:0]  frames_in_use_ff;

   // Latched input beat
   logic              kind_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [PAGE_W-1:0] page_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [TIME_W-1:0] now_ff;
   logic              wr_ff;

   // Sweep state
   logic [IDX_W-1:0]  hand_ff;
   logic [NW-1:0]     n_ff;
   logic [IDX_W-1:0]  start_ff;
   logic [IDX_W-1:0]  ipos_ff, epos_ff;
   logic [CNT_W-1:0]  icount_ff, ecount_ff;
   logic              eval_valid_ff;

   // Staged result
   status_type        res_status_ff;
   logic [PAGE_W-1:0] res_page_ff;
   logic [ADDR_W-1:0] res_addr_ff;
   logic [SLOT_W-1:0] res_frame_ff;
   logic [SLOT_W-1:0] res_hand_ff;

   // Output registers
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [PAGE_W-1:0]   rsp_page_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [SLOT_W-1:0]   rsp_frame_ff;
   logic [SLOT_W-1:0]   rsp_hand_ff;

   logic [NW-1:0]     n_calc;
   logic [IDX_W-1:0]  start_calc;
   logic [CNT_W-1:0]  two_n;
   logic              slot_ok;
   logic [IDX_W-1:0]  slot_idx;
   logic              ipos_last, epos_last;
   logic [IDX_W-1:0]  ipos_next, epos_next;
   logic signed [TIME_W:0] age;
   logic              is_old, eval_act, victim, clear_dirty, exhausted;
   logic              mem_we;
   logic [IDX_W-1:0]  wr_idx;

   // Clamp the frame count and pick the sweep start
   always_comb begin
      if (frames_in_use_ff == '0) begin
         n_calc = NW'(1);
      end else if (frames_in_use_ff > FIU_W'(FRAMES)) begin
         n_calc = NW'(FRAMES);
      end else begin
         n_calc = frames_in_use_ff[NW-1:0];
      end
      start_calc = (NW'(hand_ff) < n_calc) ? hand_ff : '0;
   end

   assign two_n    = {n_ff, 1'b0};
   assign slot_ok  = ({1'b0, slot_ff} < (SLOT_W + 1)'(FRAMES));
   assign slot_idx = slot_ff[IDX_W-1:0];

   // Wrap the pointers at the frame count
   assign ipos_last = (NW'(ipos_ff) == n_ff - NW'(1));
   assign epos_last = (NW'(epos_ff) == n_ff - NW'(1));
   assign ipos_next = ipos_last ? '0 : ipos_ff + IDX_W'(1);
   assign epos_next = epos_last ? '0 : epos_ff + IDX_W'(1);

   // Judge the frame whose read data has arrived
   assign age         = $signed({1'b0, now_ff}) - $signed({1'b0, rd_last_ff});
   assign is_old      = age > $signed({1'b0, age_threshold_ff});
   assign eval_act    = cmd.sweep && eval_valid_ff && occupied_ff[epos_ff] && is_old;
   assign victim      = eval_act && !dirty_ff[epos_ff];
   assign clear_dirty = eval_act && dirty_ff[epos_ff];
   assign exhausted   = cmd.sweep && eval_valid_ff && !victim
                        && (ecount_ff == two_n - CNT_W'(1));

   assign mem_we = (cmd.do_load && slot_ok) || victim;
   assign wr_idx = cmd.do_load ? slot_idx : epos_ff;

   assign stat.replace   = kind_ff;
   assign stat.victim    = victim;
   assign stat.exhausted = exhausted;

   // Write and read the frame table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         page_mem[wr_idx] <= page_ff;
         addr_mem[wr_idx] <= addr_ff;
         last_mem[wr_idx] <= now_ff;
      end
      rd_page_ff <= page_mem[ipos_ff];
      rd_addr_ff <= addr_mem[ipos_ff];
      rd_last_ff <= last_mem[ipos_ff];
   end

   // Dirty and occupied bits
   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff    <= '0;
         occupied_ff <= '0;
      end else if (mem_we) begin
         dirty_ff[wr_idx]    <= wr_ff;
         occupied_ff[wr_idx] <= 1'b1;
      end else if (clear_dirty) begin
         dirty_ff[epos_ff] <= 1'b0;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         age_threshold_ff <= '0;
         frames_in_use_ff <= FIU_W'(64);
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_AGE_THRESHOLD: age_threshold_ff <= csr_wdata[TIME_W-1:0];
            CSR_FRAMES_IN_USE: frames_in_use_ff <= csr_wdata[FIU_W-1:0];
            default: ;
         endcase
      end
   end

   // Latch the input beat
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= 1'b0;
      end else if (cmd.capture) begin
         kind_ff <= req_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         slot_ff <= req_slot;
         page_ff <= req_page_number;
         addr_ff <= req_virt_address;
         now_ff  <= req_now_time;
         wr_ff   <= req_write_flag;
      end
   end

   // Sweep pointers, counters and the clock hand
   always_ff @(posedge clock) begin
      if (reset) begin
         hand_ff       <= '0;
         n_ff          <= NW'(1);
         start_ff      <= '0;
         ipos_ff       <= '0;
         epos_ff       <= '0;
         icount_ff     <= '0;
         ecount_ff     <= '0;
         eval_valid_ff <= 1'b0;
      end else if (cmd.setup) begin
         n_ff          <= n_calc;
         start_ff      <= start_calc;
         ipos_ff       <= start_calc;
         icount_ff     <= '0;
         ecount_ff     <= '0;
         eval_valid_ff <= 1'b0;
      end else if (cmd.sweep) begin
         // issue one read a cycle until both passes are covered
         if (icount_ff < two_n) begin
            ipos_ff       <= ipos_next;
            icount_ff     <= icount_ff + CNT_W'(1);
            epos_ff       <= ipos_ff;
            eval_valid_ff <= 1'b1;
         end else begin
            eval_valid_ff <= 1'b0;
         end
         if (eval_valid_ff) begin
            ecount_ff <= ecount_ff + CNT_W'(1);
         end
         if (victim) begin
            hand_ff <= epos_next;
         end else if (exhausted) begin
            hand_ff <= start_ff;
         end
      end
   end

   // Stage the result of the item
   always_ff @(posedge clock) begin
      if (cmd.do_load) begin
         res_status_ff <= STATUS_LOAD_DONE;
         res_page_ff   <= '0;
         res_addr_ff   <= '0;
         res_frame_ff  <= slot_ff;
         res_hand_ff   <= SLOT_W'(hand_ff);
      end else if (victim) begin
         res_status_ff <= STATUS_REPLACED;
         res_page_ff   <= rd_page_ff;
         res_addr_ff   <= rd_addr_ff;
         res_frame_ff  <= SLOT_W'(epos_ff);
         res_hand_ff   <= SLOT_W'(epos_next);
      end else if (exhausted) begin
         res_status_ff <= STATUS_NO_VICTIM;
         res_page_ff   <= '0;
         res_addr_ff   <= '0;
         res_frame_ff  <= '0;
         res_hand_ff   <= SLOT_W'(start_ff);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_status_ff <= res_status_ff;
         rsp_page_ff   <= res_page_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_frame_ff  <= res_frame_ff;
         rsp_hand_ff   <= res_hand_ff;
      end
   end

   assign rsp_status          = rsp_status_ff;
   assign rsp_evicted_page    = rsp_page_ff;
   assign rsp_evicted_address = rsp_addr_ff;
   assign rsp_frame_used      = rsp_frame_ff;
   assign rsp_next_hand       = rsp_hand_ff;

`ifndef ASSERT_OFF
   a_victim_excl: assert property (@(posedge clock) disable iff (reset)
      !(victim && exhausted))
      else $error("victim and exhaustion flagged together");

   a_epos_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.sweep && eval_valid_ff) |-> (NW'(epos_ff) < n_ff))
      else $error("sweep pointer beyond frames in use");

   a_victim_clean: assert property (@(posedge clock) disable iff (reset)
      victim |=> occupied_ff[$past(epos_ff)]
                 && (dirty_ff[$past(epos_ff)] == $past(wr_ff)))
      else $error("victim frame bookkeeping lost");
`endif

endmodule

// ===== sv/wsclock_page_replacement.sv =====
// Top level of the WSClock page replacement block.
`timescale 1ns / 1ps

// WSClock page replacement over a 64-frame table. A load beat writes one frame
// entry when its slot lies in the table and returns its result through the
// dispatch and finish states. A replace beat sweeps the frames in use from the
// clock hand, one frame per cycle through the registered read port of the frame
// table, for up to two passes, ending early when a clean old frame is found.
// One beat is worked on at a time; a finished result waits in the output
// register while the next beat is accepted. Configuration writes are always
// taken and must only be issued while no beat is in flight.
module wsclock_page_replacement
   import wsc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   input  logic [SLOT_W-1:0]    req_slot,
   input  logic [PAGE_W-1:0]    req_page_number,
   input  logic [ADDR_W-1:0]    req_virt_address,
   input  logic [TIME_W-1:0]    req_now_time,
   input  logic                 req_write_flag,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [PAGE_W-1:0]    rsp_evicted_page,
   output logic [ADDR_W-1:0]    rsp_evicted_address,
   output logic [SLOT_W-1:0]    rsp_frame_used,
   output logic [SLOT_W-1:0]    rsp_next_hand,
   // configuration channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type stat;

   // Configuration is never back-pressured
   assign csr_ready = 1'b1;

   wsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   wsc_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_kind            (req_kind),
      .req_slot            (req_slot),
      .req_page_number     (req_page_number),
      .req_virt_address    (req_virt_address),
      .req_now_time        (req_now_time),
      .req_write_flag      (req_write_flag),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_status          (rsp_status),
      .rsp_evicted_page    (rsp_evicted_page),
      .rsp_evicted_address (rsp_evicted_address),
      .rsp_frame_used      (rsp_frame_used),
      .rsp_next_hand       (rsp_next_hand)
   );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the WSClock page replacement block.
`timescale 1ns / 1ps

module tb;
   import wsc_pkg::*;

   // Request kinds
   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_REPLACE = 1'b1;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;
   localparam int TAIL_CYCLES    = 140;

   typedef struct {
      logic              kind;
      logic [SLOT_W-1:0] slot;
      logic [PAGE_W-1:0] page_number;
      logic [ADDR_W-1:0] virt_address;
      logic [TIME_W-1:0] now_time;
      logic              write_flag;
   } frame_req_type;

   typedef struct {
      status_type        status;
      logic [PAGE_W-1:0] evicted_page;
      logic [ADDR_W-1:0] evicted_address;
      logic [SLOT_W-1:0] frame_used;
      logic [SLOT_W-1:0] next_hand;
   } frame_rsp_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_kind;
   logic [SLOT_W-1:0]    req_slot;
   logic [PAGE_W-1:0]    req_page_number;
   logic [ADDR_W-1:0]    req_virt_address;
   logic [TIME_W-1:0]    req_now_time;
   logic                 req_write_flag;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [STATUS_W-1:0]  rsp_status;
   logic [PAGE_W-1:0]    rsp_evicted_page;
   logic [ADDR_W-1:0]    rsp_evicted_address;
   logic [SLOT_W-1:0]    rsp_frame_used;
   logic [SLOT_W-1:0]    rsp_next_hand;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   // Shadow frame table, hand and registers
   logic [PAGE_W-1:0] page_tbl     [FRAMES];
   logic [ADDR_W-1:0] addr_tbl     [FRAMES];
   logic [TIME_W-1:0] last_use_tbl [FRAMES];
   bit                dirty_tbl    [FRAMES];
   bit                occupied_tbl [FRAMES];
   int                hand_pos;
   logic [TIME_W-1:0] age_limit;
   logic [FIU_W-1:0]  frame_count;

   frame_rsp_type expected_results[$];
   int mismatch_count;
   int req_idle_pct;
   int rsp_idle_pct;
   int holds_requested;
   int holds_served;
   int quiet_cycles;
   int now_clock;

   wsclock_page_replacement i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_slot            (req_slot),
      .req_page_number     (req_page_number),
      .req_virt_address    (req_virt_address),
      .req_now_time        (req_now_time),
      .req_write_flag      (req_write_flag),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_evicted_page    (rsp_evicted_page),
      .rsp_evicted_address (rsp_evicted_address),
      .rsp_frame_used      (rsp_frame_used),
      .rsp_next_hand       (rsp_next_hand),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Number of frames the hand circles, with out-of-range counts clamped
   function automatic int frames_swept();
      if (frame_count == 0)
         return 1;
      if (frame_count > FRAMES)
         return FRAMES;
      return int'(frame_count);
   endfunction

   function automatic void store_frame(input int idx, input frame_req_type r);
      page_tbl[idx]     = r.page_number;
      addr_tbl[idx]     = r.virt_address;
      last_use_tbl[idx] = r.now_time;
      dirty_tbl[idx]    = r.write_flag;
   endfunction

   // Work out the result of one request and advance the shadow table
   function automatic frame_rsp_type predict_replacement(input frame_req_type r);
      frame_rsp_type res;
      int span;
      int pos;
      int step;
      longint age;
      res.status          = STATUS_LOAD_DONE;
      res.evicted_page    = '0;
      res.evicted_address = '0;
      res.frame_used      = '0;
      res.next_hand       = SLOT_W'(hand_pos);
      if (r.kind == KIND_LOAD) begin
         // slots past the table are dropped but still answered
         if (r.slot < FRAMES) begin
            store_frame(int'(r.slot), r);
            occupied_tbl[r.slot] = 1'b1;
         end
         res.frame_used = r.slot;
         return res;
      end
      span = frames_swept();
      pos  = (hand_pos < span) ? hand_pos : 0;
      for (step = 0; step < 2 * span; step++) begin
         if (occupied_tbl[pos]) begin
            age = longint'(r.now_time) - longint'(last_use_tbl[pos]);
            if (age > longint'(age_limit)) begin
               if (!dirty_tbl[pos]) begin
                  res.status          = STATUS_REPLACED;
                  res.evicted_page    = page_tbl[pos];
                  res.evicted_address = addr_tbl[pos];
                  res.frame_used      = SLOT_W'(pos);
                  store_frame(pos, r);
                  hand_pos      = (pos + 1) % span;
                  res.next_hand = SLOT_W'(hand_pos);
                  return res;
               end
               // old but dirty: spare it this time round
               dirty_tbl[pos] = 1'b0;
            end
         end
         pos = (pos + 1) % span;
      end
      hand_pos      = pos;
      res.status    = STATUS_NO_VICTIM;
      res.next_hand = SLOT_W'(pos);
      return res;
   endfunction

   // Offer one request beat, idling first at random, and log its expectation
   task automatic offer_request(input frame_req_type r);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < req_idle_pct)
            @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= r.kind;
      req_slot         <= r.slot;
      req_page_number  <= r.page_number;
      req_virt_address <= r.virt_address;
      req_now_time     <= r.now_time;
      req_write_flag   <= r.write_flag;
      @(posedge clock);
      while (req_ready !== 1'b1)
         @(posedge clock);
      expected_results.push_back(predict_replacement(r));
   endtask

   task automatic load_frame(input logic [SLOT_W-1:0] slot, input logic [PAGE_W-1:0] page,
                             input logic [ADDR_W-1:0] addr, input logic [TIME_W-1:0] last_use,
                             input logic dirty);
      frame_req_type r;
      r = '{KIND_LOAD, slot, page, addr, last_use, dirty};
      offer_request(r);
   endtask

   task automatic request_replacement(input logic [PAGE_W-1:0] page,
                                      input logic [ADDR_W-1:0] addr,
                                      input logic [TIME_W-1:0] now, input logic wr);
      frame_req_type r;
      r = '{KIND_REPLACE, SLOT_W'($urandom_range(1023)), page, addr, now, wr};
      offer_request(r);
   endtask

   // Drop valid and wait for every outstanding result
   task automatic finish_phase();
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
   endtask

   // Write one register; only called with the block idle
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DAT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1)
         @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_AGE_THRESHOLD)
         age_limit = value;
      else
         frame_count = value[FIU_W-1:0];
      @(posedge clock);
   endtask

   // Loads lag the running time a little; replaces move it forward
   function automatic frame_req_type make_traffic_item();
      frame_req_type r;
      int span;
      int back;
      span           = frames_swept();
      r.page_number  = $urandom;
      r.virt_address = $urandom;
      r.write_flag   = ($urandom_range(99) < 40);
      r.slot         = ($urandom_range(99) < 88) ? SLOT_W'($urandom_range(span - 1))
                                                 : SLOT_W'($urandom_range(1023));
      if ($urandom_range(99) < 40) begin
         r.kind     = KIND_LOAD;
         back       = $urandom_range(600);
         r.now_time = (now_clock > back) ? TIME_W'(now_clock - back) : '0;
      end else begin
         r.kind     = KIND_REPLACE;
         now_clock  = now_clock + $urandom_range(40);
         r.now_time = TIME_W'(now_clock);
      end
      // occasional wild timestamp
      if ($urandom_range(99) < 5)
         r.now_time = TIME_W'($urandom_range(32'h7FFF_FFFF));
      return r;
   endfunction

   task automatic test_directed();
      req_idle_pct = 10;
      rsp_idle_pct = 46;
      write_csr(CSR_AGE_THRESHOLD, '0);
      write_csr(CSR_FRAMES_IN_USE, CSR_DAT_W'(64));
      load_frame(10'd0, 32'hFFFF_FFFF, 32'h0000_0000, '0, 1'b0);
      load_frame(10'd1, 32'h0000_0000, 32'hFFFF_FFFF, TIME_MAX, 1'b1);
      load_frame(10'd2, 32'h1234_5678, 32'h9ABC_DEF0, '0, 1'b1);
      load_frame(10'd63, 32'hA5A5_A5A5, 32'h5A5A_5A5A, TIME_W'(1000), 1'b0);
      // slots past the table
      load_frame(10'd64, 32'hDEAD_0001, 32'hDEAD_0002, TIME_W'(5), 1'b0);
      load_frame(10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TIME_MAX, 1'b1);
      // clean old frame taken, then a dirty one spared on the first pass
      request_replacement(32'h1111_1111, 32'h2222_2222, TIME_MAX, 1'b1);
      request_replacement(32'h3333_3333, 32'h4444_4444, TIME_MAX, 1'b0);
      // no age above zero anywhere: no victim after two passes
      request_replacement(32'h5555_5555, 32'h6666_6666, '0, 1'b0);
      request_replacement(32'h7777_7777, 32'h8888_8888, TIME_MAX, 1'b1);
      finish_phase();
      // top threshold: nothing can ever be old
      write_csr(CSR_AGE_THRESHOLD, TIME_MAX);
      request_replacement(32'h9999_9999, 32'hAAAA_AAAA, TIME_MAX, 1'b0);
      finish_phase();
      // zero frames acts as one; the hand sits beyond it
      write_csr(CSR_AGE_THRESHOLD, '0);
      write_csr(CSR_FRAMES_IN_USE, '0);
      request_replacement(32'hBBBB_BBBB, 32'hCCCC_CCCC, TIME_MAX, 1'b0);
      load_frame(10'd0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, '0, 1'b0);
      request_replacement(32'hDDDD_DDDD, 32'hEEEE_EEEE, TIME_MAX, 1'b1);
      finish_phase();
      // counts above the table clamp to it
      write_csr(CSR_FRAMES_IN_USE, CSR_DAT_W'(1024));
      request_replacement(32'h0000_0001, 32'h0000_0002, TIME_MAX, 1'b0);
      request_replacement(32'h0000_0003, 32'h0000_0004, TIME_MAX, 1'b0);
      finish_phase();
      write_csr(CSR_FRAMES_IN_USE, CSR_DAT_W'(2047));
      load_frame(10'd40, 32'h8000_0000, 32'h0000_0001, TIME_W'(7), 1'b0);
      request_replacement(32'h4000_0000, 32'h2000_0000, TIME_W'(8), 1'b0);
      finish_phase();
   endtask

   // Phases of random traffic, each under a fresh register setting
   task automatic test_random_traffic(input int items, input int snd_idle, input int rcv_idle);
      int sent;
      int phase_len;
      int i;
      req_idle_pct = snd_idle;
      rsp_idle_pct = rcv_idle;
      sent         = 0;
      now_clock    = $urandom_range(1000, 1 << 30);
      while (sent < items) begin
         case ($urandom_range(5))
            0:       write_csr(CSR_AGE_THRESHOLD, '0);
            1:       write_csr(CSR_AGE_THRESHOLD, TIME_MAX);
            2:       write_csr(CSR_AGE_THRESHOLD, CSR_DAT_W'($urandom_range(32'h7FFF_FFFF)));
            default: write_csr(CSR_AGE_THRESHOLD, CSR_DAT_W'($urandom_range(400)));
         endcase
         case ($urandom_range(7))
            0:       write_csr(CSR_FRAMES_IN_USE, CSR_DAT_W'(1));
            1:       write_csr(CSR_FRAMES_IN_USE, CSR_DAT_W'(2));
            2:       write_csr(CSR_FRAMES_IN_USE, CSR_DAT_W'($urandom_range(3, 16)));
            3:       write_csr(CSR_FRAMES_IN_USE, CSR_DAT_W'(64));
            4:       write_csr(CSR_FRAMES_IN_USE, CSR_DAT_W'($urandom_range(17, 63)));
            5:       write_csr(CSR_FRAMES_IN_USE, CSR_DAT_W'(1024));
            6:       write_csr(CSR_FRAMES_IN_USE, '0);
            default: write_csr(CSR_FRAMES_IN_USE, CSR_DAT_W'($urandom_range(65, 2047)));
         endcase
         phase_len = $urandom_range(60, 140);
         for (i = 0; i < phase_len && sent < items; i++) begin
            offer_request(make_traffic_item());
            sent++;
         end
         finish_phase();
      end
   endtask

   // Hold the result side off while requests keep coming, so the input stalls
   task automatic test_output_backpressure();
      int i;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      holds_requested++;
      for (i = 0; i < 40; i++)
         offer_request(make_traffic_item());
      finish_phase();
   endtask

   // Result side: random stalls, plus long hold-offs on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != holds_requested) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_served++;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   function automatic void check_field(input string name, input logic [31:0] exp,
                                       input logic [31:0] act);
      if (act !== exp) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
         mismatch_count++;
      end
   endfunction

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin : check_results
      frame_rsp_type exp;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            $error("result beat with no request outstanding");
            mismatch_count++;
         end else begin
            exp = expected_results.pop_front();
            check_field("status", 32'(exp.status), 32'(rsp_status));
            check_field("evicted_page", exp.evicted_page, rsp_evicted_page);
            check_field("evicted_address", exp.evicted_address, rsp_evicted_address);
            check_field("frame_used", 32'(exp.frame_used), 32'(rsp_frame_used));
            check_field("next_hand", 32'(exp.next_hand), 32'(rsp_next_hand));
         end
      end
   end

   // Stop a hung run: count cycles with no beat on any channel
   always @(posedge clock) begin
      if (req_valid === 1'b1 && req_ready === 1'b1 || rsp_valid === 1'b1 && rsp_ready === 1'b1
          || csr_valid === 1'b1 && csr_ready === 1'b1)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : run_tests
      int i;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = KIND_LOAD;
      req_slot         = '0;
      req_page_number  = '0;
      req_virt_address = '0;
      req_now_time     = '0;
      req_write_flag   = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = CSR_AGE_THRESHOLD;
      csr_wdata        = '0;
      mismatch_count   = 0;
      req_idle_pct     = 0;
      rsp_idle_pct     = 0;
      holds_requested  = 0;
      holds_served     = 0;
      quiet_cycles     = 0;
      now_clock        = 0;
      hand_pos         = 0;
      age_limit        = '0;
      frame_count      = FIU_W'(64);
      for (i = 0; i < FRAMES; i++) begin
         page_tbl[i]     = '0;
         addr_tbl[i]     = '0;
         last_use_tbl[i] = '0;
         dirty_tbl[i]    = 1'b0;
         occupied_tbl[i] = 1'b0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_traffic(500, 10, 46);
      test_random_traffic(500, 46, 10);
      test_random_traffic(440, 0, 0);
      test_output_backpressure();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== wsclock_page_replacement.f =====
sv/wsc_pkg.sv
sv/wsc_ctrl.sv
sv/wsc_datapath.sv
sv/wsclock_page_replacement.sv
sim/tb.sv
